// ===== src/mbc1_pkg.sv =====
// Shared types, codes and helper functions for the MBC1 bank controller.
// No dependencies; imported by every module of the block.
package mbc1_pkg;

  typedef enum logic [2:0] {
    KIND_ROM_READ  = 3'd0,
    KIND_RAM_READ  = 3'd1,
    KIND_RAM_WRITE = 3'd2,
    KIND_READ_FF   = 3'd3,
    KIND_NONE      = 3'd4
  } mbc1_kind_t;

  // Configuration register indexes on the write port
  typedef enum logic [1:0] {
    REG_ROM_BANK_COUNT = 2'd0,
    REG_RAM_BANK_COUNT = 2'd1,
    REG_RAM_PRESENT    = 2'd2,
    REG_RAM_SMALL      = 2'd3
  } mbc1_reg_t;

  localparam int unsigned CfgDataWidth = 8;
  localparam int unsigned MemAddrWidth = 21;
  localparam int unsigned RamAddrWidth = 15;

  localparam logic [7:0] RomBankCountReset = 8'd2;
  localparam logic [3:0] RamEnableKey      = 4'hA;

  typedef struct packed {
    logic [7:0] rom_bank_count;
    logic [2:0] ram_bank_count;
    logic       ram_present;
    logic       ram_small;
  } mbc1_cfg_t;

  typedef struct packed {
    logic       ram_enabled;
    logic [4:0] low_rom_bank;
    logic [1:0] upper_bank;
    logic       banking_mode;
  } mbc1_state_t;

  typedef struct packed {
    mbc1_kind_t                kind;
    logic [MemAddrWidth-1:0]   memory_address;
    logic [7:0]                memory_write_byte;
  } mbc1_result_t;

  // ROM bank mask: half the bank count, capped at 16, OR-ed with one less than itself; all ones when half is zero
  function automatic logic [4:0] bank_mask(input logic [7:0] rom_bank_count);
    logic [4:0] half;
    half = (rom_bank_count[7:1] > 7'd16) ? 5'd16 : rom_bank_count[5:1];
    if (half == 5'd0) begin
      bank_mask = 5'h1F;
    end else begin
      bank_mask = half | (half - 5'd1);
    end
  endfunction

  // Upper ROM bank bits, already placed at bank bits 6:5
  function automatic logic [6:0] upper_bits(input logic [7:0] rom_bank_count,
                                            input logic [1:0] upper_bank);
    if (rom_bank_count <= 8'd32) begin
      upper_bits = 7'd0;
    end else if (rom_bank_count == 8'd64) begin
      upper_bits = {1'b0, upper_bank[0], 5'd0};
    end else begin
      upper_bits = {upper_bank, 5'd0};
    end
  endfunction

endpackage

// ===== src/mbc1_bank_controller_core.sv =====
// MBC1 cartridge bank controller: turns CPU bus transactions into ROM/RAM byte
// addresses. Each accepted transaction gives exactly one result in the next
// cycle, and a new transaction is taken every cycle while the result register
// is empty or being drained, so the sustained rate is one per clock; only the
// single output register sets that figure. Mapper writes below 0x8000 take
// effect for the next transaction. ROM and RAM themselves sit outside; the
// block only reports the kind of access and the address. Built from mbc1_pkg,
// mbc1_regs and mbc1_map.
module mbc1_bank_controller_core #(
  parameter int unsigned ROM_ADDRESS_BITS = 21
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  mbc1_pkg::mbc1_reg_t                cfg_index,
  input  logic [mbc1_pkg::CfgDataWidth-1:0]  cfg_data,
  // bus transactions in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [23:0]                        s_tdata,  // bus_address[15:0], write_byte[23:16]
  input  logic                               s_tuser,  // op (0 read, 1 write)
  // results out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [31:0]                        m_tdata,  // memory_address[20:0],
                                                       // memory_write_byte[28:21], zero pad
  output logic [2:0]                         m_tuser   // access_kind
);
  import mbc1_pkg::*;

  logic          accept;
  mbc1_cfg_t     cfg;
  mbc1_state_t   state;
  mbc1_result_t  result;
  mbc1_result_t  out_reg;

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  mbc1_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .map_we    (accept && s_tuser && !s_tdata[15]),
    .map_sel   (s_tdata[14:13]),
    .map_byte  (s_tdata[23:16]),
    .cfg       (cfg),
    .state     (state)
  );

  mbc1_map #(
    .ROM_ADDRESS_BITS (ROM_ADDRESS_BITS)
  ) u_map (
    .op          (s_tuser),
    .bus_address (s_tdata[15:0]),
    .write_byte  (s_tdata[23:16]),
    .cfg         (cfg),
    .state       (state),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload holds while the result waits
  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {3'd0, out_reg.memory_write_byte, out_reg.memory_address};
  assign m_tuser = out_reg.kind;

  // a mapper register write never reaches memory
  a_reg_write_none: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser && !s_tdata[15]) |=> (m_tuser == KIND_NONE))
    else $error("mapper write produced a memory access");

  // every ROM window read is a ROM read
  a_rom_read: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser && !s_tdata[15]) |=> (m_tuser == KIND_ROM_READ))
    else $error("ROM window read not mapped to ROM");

  // a store byte appears only with a RAM write
  a_byte_only_on_write: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[28:21] != 8'd0)) |-> (m_tuser == KIND_RAM_WRITE))
    else $error("write byte on a non-write result");

  // unmapped windows give no access and no address
  a_unmapped: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tdata[15] && (s_tdata[15:13] != 3'b101))
      |=> (m_tuser == KIND_NONE && m_tdata[20:0] == 21'd0))
    else $error("unmapped address produced an access");

endmodule

// ===== src/mbc1_regs.sv =====
// Configuration registers and the four mapper registers of the MBC1 controller.
// Depends on mbc1_pkg for the register structs, indexes and bank_mask().
module mbc1_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  mbc1_pkg::mbc1_reg_t                 cfg_index,
  input  logic [mbc1_pkg::CfgDataWidth-1:0]   cfg_data,
  input  logic                                map_we,
  input  logic [1:0]                          map_sel,
  input  logic [7:0]                          map_byte,
  output mbc1_pkg::mbc1_cfg_t                 cfg,
  output mbc1_pkg::mbc1_state_t               state
);
  import mbc1_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rom_bank_count <= RomBankCountReset;
      cfg.ram_bank_count <= 3'd0;
      cfg.ram_present    <= 1'b0;
      cfg.ram_small      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROM_BANK_COUNT: cfg.rom_bank_count <= cfg_data[7:0];
        REG_RAM_BANK_COUNT: cfg.ram_bank_count <= cfg_data[2:0];
        REG_RAM_PRESENT:    cfg.ram_present    <= cfg_data[0];
        REG_RAM_SMALL:      cfg.ram_small      <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  // Mapper writes land in one of four 8 KB windows below 0x8000
  always_ff @(posedge clk) begin
    if (rst) begin
      state.ram_enabled  <= 1'b0;
      state.low_rom_bank <= 5'd1;
      state.upper_bank   <= 2'd0;
      state.banking_mode <= 1'b0;
    end else if (map_we) begin
      unique case (map_sel)
        2'd0: state.ram_enabled <= cfg.ram_present && (map_byte[3:0] == RamEnableKey);
        2'd1: begin
          // a zero bank number selects bank one; masking afterwards may still give zero
          if (map_byte[4:0] == 5'd0) begin
            state.low_rom_bank <= 5'd1;
          end else begin
            state.low_rom_bank <= map_byte[4:0] & bank_mask(cfg.rom_bank_count);
          end
        end
        2'd2: state.upper_bank   <= map_byte[1:0];
        2'd3: state.banking_mode <= map_byte[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/mbc1_map.sv =====
// Address decode and bank mapping for one CPU bus transaction.
// Depends on mbc1_pkg for the structs, access kinds and bank helpers.
module mbc1_map #(
  parameter int unsigned ROM_ADDRESS_BITS = 21
) (
  input  logic                   op,
  input  logic [15:0]            bus_address,
  input  logic [7:0]             write_byte,
  input  mbc1_pkg::mbc1_cfg_t    cfg,
  input  mbc1_pkg::mbc1_state_t  state,
  output mbc1_pkg::mbc1_result_t result
);
  import mbc1_pkg::*;

  localparam logic [MemAddrWidth-1:0] RomMask =
    MemAddrWidth'((64'd1 << ROM_ADDRESS_BITS) - 64'd1);

  logic [6:0]              upper;
  logic [6:0]              rom_bank;
  logic [MemAddrWidth-1:0] rom_address;
  logic [RamAddrWidth-1:0] ram_address;
  logic                    rom_window;
  logic                    ram_window;
  logic                    ram_usable;

  assign upper      = upper_bits(cfg.rom_bank_count, state.upper_bank);
  assign rom_window = ~bus_address[15];
  assign ram_window = (bus_address[15:13] == 3'b101);
  assign ram_usable = state.ram_enabled && (cfg.ram_bank_count != 3'd0);

  always_comb begin
    if (!bus_address[14]) begin
      rom_bank = state.banking_mode ? upper : 7'd0;
    end else begin
      rom_bank = {2'b00, state.low_rom_bank & bank_mask(cfg.rom_bank_count)} | upper;
    end
    rom_address = {rom_bank, bus_address[13:0]} & RomMask;
  end

  always_comb begin
    if (cfg.ram_bank_count == 3'd1) begin
      ram_address = cfg.ram_small ? {4'd0, bus_address[10:0]} : {2'd0, bus_address[12:0]};
    end else if (state.banking_mode) begin
      ram_address = {state.upper_bank, bus_address[12:0]};
    end else begin
      ram_address = {2'd0, bus_address[12:0]};
    end
  end

  always_comb begin
    result.kind              = KIND_NONE;
    result.memory_address    = '0;
    result.memory_write_byte = '0;
    priority if (rom_window) begin
      if (!op) begin
        result.kind           = KIND_ROM_READ;
        result.memory_address = rom_address;
      end
    end else if (ram_window) begin
      if (!ram_usable) begin
        result.kind = op ? KIND_NONE : KIND_READ_FF;
      end else begin
        result.memory_address = {{(MemAddrWidth-RamAddrWidth){1'b0}}, ram_address};
        if (op) begin
          result.kind              = KIND_RAM_WRITE;
          result.memory_write_byte = write_byte;
        end else begin
          result.kind = KIND_RAM_READ;
        end
      end
    end else begin
      result.kind = KIND_NONE;
    end
  end

endmodule
